// ===== src/bpc_pkg.sv =====
// bpc_pkg: shared types, register indexes and reset values of the button press classifier
// no dependencies
`default_nettype none
package bpc_pkg;

	localparam int NUM_BUTTONS_DEF = 4;
	localparam int KEY_REGS        = 4;
	localparam int CNT_W           = 16;
	localparam int CODE_W          = 8;
	localparam int CFG_IDX_W       = 3;
	localparam int EVENT_W         = 4;
	localparam int EV_CALC_W       = 5;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_HOLD_LIMIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_MIN_COUNT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_MAX_COUNT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_CODE_FIRST  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_CODE_SECOND = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_CODE_THIRD  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_CODE_FOURTH = 3'd7;

	localparam logic [CNT_W-1:0] RST_SAMPLE_INTERVAL = 16'd40;
	localparam logic [CNT_W-1:0] RST_LONG_HOLD_LIMIT = 16'd50;
	localparam logic [CNT_W-1:0] RST_SHORT_MIN_COUNT = 16'd1;
	localparam logic [CNT_W-1:0] RST_SHORT_MAX_COUNT = 16'd25;

	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_READ = 1'b1;

	typedef enum logic [1:0] {
		MODE_NONE  = 2'd0,
		MODE_SHORT = 2'd1,
		MODE_LONG  = 2'd2
	} mode_t;

	typedef struct packed {
		logic [CNT_W-1:0] long_hold_limit;
		logic [CNT_W-1:0] short_min_count;
		logic [CNT_W-1:0] short_max_count;
	} thr_t;

	function automatic logic [CODE_W-1:0] key_code_reset(input int idx);
		return CODE_W'(idx + 1);
	endfunction

endpackage
`default_nettype wire

// ===== src/bpc_button.sv =====
// bpc_button: pressed flag, hold count and pending mode of one button
// depends on bpc_pkg
`default_nettype none
module bpc_button
	import bpc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  sample,
	input  wire logic  now,
	input  wire logic  take_clr,
	input  wire thr_t  thr,
	output mode_t      mode
);

	logic             pressed_q;
	logic [CNT_W-1:0] hold_q;
	mode_t            mode_q;
	logic [CNT_W-1:0] hold_inc;

	assign hold_inc = (hold_q == CNT_MAX) ? hold_q : hold_q + 1'b1;
	assign mode     = mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q <= 1'b0;
			hold_q    <= '0;
			mode_q    <= MODE_NONE;
		end else if (sample) begin
			if (!pressed_q) begin
				hold_q <= '0;
				if (now)
					pressed_q <= 1'b1;
				else
					mode_q <= MODE_NONE;
			end else if (now) begin
				if (hold_inc > thr.long_hold_limit) begin
					hold_q <= '0;
					mode_q <= MODE_LONG;
				end else begin
					hold_q <= hold_inc;
				end
			end else begin
				pressed_q <= 1'b0;
				if (mode_q != MODE_LONG && thr.short_min_count <= hold_q
						&& hold_q < thr.short_max_count)
					mode_q <= MODE_SHORT;
			end
		end else if (take_clr) begin
			mode_q <= MODE_NONE;
		end
	end

endmodule
`default_nettype wire

// ===== src/button_press_classifier_core.sv =====
// button_press_classifier_core: short and long press classifier for buttons on one touch code
// output: a result is registered in the output register, or in the skid beat when the output is stalled
// throughput: one item per cycle while in_stall is low; output register plus skid beat decouple the two channels
// reset: asynchronous, clears counters, flags, pending modes and loads register defaults
// depends on bpc_pkg and bpc_button
`default_nettype none
module button_press_classifier_core
	import bpc_pkg::*;
#(
	parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CNT_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 req_type,
	input  wire logic [CODE_W-1:0]    touch_code,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [EVENT_W-1:0]        key_event
);

	logic [CNT_W-1:0]  sample_interval_q;
	thr_t              thr_q;
	logic [CODE_W-1:0] key_code_q [KEY_REGS];
	logic [CNT_W-1:0]  ticks_q;
	logic [CNT_W-1:0]  ticks_inc;

	logic                   accept;
	logic                   tick;
	logic                   take;
	logic                   sample;
	logic [NUM_BUTTONS-1:0] now;
	logic [NUM_BUTTONS-1:0] clr;
	mode_t                  mode [NUM_BUTTONS];
	logic [EV_CALC_W-1:0]   ev_wide;
	logic [EVENT_W-1:0]     ev;

	logic               skid_valid_q;
	logic [EVENT_W-1:0] skid_event_q;
	logic               out_valid_q;
	logic [EVENT_W-1:0] out_event_q;
	logic               out_take;

	assign in_stall  = skid_valid_q;
	assign accept    = in_valid && !in_stall;
	assign tick      = accept && (req_type == REQ_TICK);
	assign take      = accept && (req_type == REQ_READ);
	assign ticks_inc = (ticks_q == CNT_MAX) ? ticks_q : ticks_q + 1'b1;
	assign sample    = tick && (ticks_inc > sample_interval_q);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_interval_q     <= RST_SAMPLE_INTERVAL;
			thr_q.long_hold_limit <= RST_LONG_HOLD_LIMIT;
			thr_q.short_min_count <= RST_SHORT_MIN_COUNT;
			thr_q.short_max_count <= RST_SHORT_MAX_COUNT;
			for (int i = 0; i < KEY_REGS; i++)
				key_code_q[i] <= key_code_reset(i);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SAMPLE_INTERVAL: sample_interval_q     <= cfg_data;
				REG_LONG_HOLD_LIMIT: thr_q.long_hold_limit <= cfg_data;
				REG_SHORT_MIN_COUNT: thr_q.short_min_count <= cfg_data;
				REG_SHORT_MAX_COUNT: thr_q.short_max_count <= cfg_data;
				REG_KEY_CODE_FIRST:  key_code_q[0]         <= cfg_data[CODE_W-1:0];
				REG_KEY_CODE_SECOND: key_code_q[1]         <= cfg_data[CODE_W-1:0];
				REG_KEY_CODE_THIRD:  key_code_q[2]         <= cfg_data[CODE_W-1:0];
				REG_KEY_CODE_FOURTH: key_code_q[3]         <= cfg_data[CODE_W-1:0];
				default: ;
			endcase
		end
	end

	// shared sample timer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ticks_q <= '0;
		else if (tick)
			ticks_q <= sample ? '0 : ticks_inc;
	end

	for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
		if (b < KEY_REGS) begin : g_key
			assign now[b] = (touch_code == key_code_q[b]);
		end else begin : g_nokey
			assign now[b] = 1'b0;
		end

		bpc_button u_button (
			.clk      (clk),
			.arst_n   (arst_n),
			.sample   (sample),
			.now      (now[b]),
			.take_clr (clr[b]),
			.thr      (thr_q),
			.mode     (mode[b])
		);
	end

	// first pending event: shorts in button order, then longs
	always_comb begin
		logic found;
		found   = 1'b0;
		ev_wide = '0;
		clr     = '0;
		for (int b = 0; b < NUM_BUTTONS; b++) begin
			if (!found && mode[b] == MODE_SHORT) begin
				found   = 1'b1;
				ev_wide = EV_CALC_W'(b + 1);
				clr[b]  = take;
			end
		end
		for (int b = 0; b < NUM_BUTTONS; b++) begin
			if (!found && mode[b] == MODE_LONG) begin
				found   = 1'b1;
				ev_wide = EV_CALC_W'(NUM_BUTTONS + b + 1);
				clr[b]  = take;
			end
		end
	end

	assign ev = take ? ev_wide[EVENT_W-1:0] : '0;

	// output register and skid beat
	assign out_take = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (!out_valid_q || out_take)
					out_valid_q <= 1'b1;
				else
					skid_valid_q <= 1'b1;
			end else if (skid_valid_q && out_take) begin
				skid_valid_q <= 1'b0;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (!out_valid_q || out_take)
				out_event_q <= ev;
			else
				skid_event_q <= ev;
		end else if (skid_valid_q && out_take) begin
			out_event_q <= skid_event_q;
		end
	end

	assign out_valid = out_valid_q;
	assign key_event = out_event_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid beat held without an output beat");

	a_one_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(clr))
		else $error("more than one pending event cleared");

	a_clear_only_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		(clr != '0) |-> (take && !sample))
		else $error("pending event cleared outside a read beat");

	a_tick_no_event: assert property (@(posedge clk) disable iff (!arst_n)
		(tick && (!out_valid_q || out_take)) |=> (out_valid_q && out_event_q == '0))
		else $error("tick beat produced a nonzero event");

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// testbench for button_press_classifier_core: directed and random tick and read beats
// checked against an in-bench model of press classification; depends on bpc_pkg
`timescale 1ns / 100ps
module testbench;
	import bpc_pkg::*;

	localparam int NB          = NUM_BUTTONS_DEF;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 80;

	typedef struct {
		logic              req;
		logic [CODE_W-1:0] code;
		bit                drain_first;
	} req_beat_t;

	logic                 clk;
	logic                 arst_n     = 1'b0;
	logic                 cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index  = '0;
	logic [CNT_W-1:0]     cfg_data   = '0;
	logic                 in_valid   = 1'b0;
	logic                 in_stall;
	logic                 req_type   = REQ_TICK;
	logic [CODE_W-1:0]    touch_code = '0;
	logic                 out_valid;
	logic                 out_stall  = 1'b0;
	logic [EVENT_W-1:0]   key_event;

	button_press_classifier_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.touch_code(touch_code),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.key_event (key_event)
	);

	// model copy of registers and state
	logic [CNT_W-1:0]  cfg_interval;
	logic [CNT_W-1:0]  cfg_long_lim;
	logic [CNT_W-1:0]  cfg_short_min;
	logic [CNT_W-1:0]  cfg_short_max;
	logic [CODE_W-1:0] key_reg [KEY_REGS];
	logic [CNT_W-1:0]  tick_cnt;
	logic              btn_down [NB];
	logic [CNT_W-1:0]  hold_cnt [NB];
	mode_t             btn_mode [NB];

	req_beat_t          req_beats [$];
	logic [EVENT_W-1:0] events_due [$];
	logic [EVENT_W-1:0] want_event;
	logic               in_taken = 1'b0;
	int idle_pct = 18;
	int hold_req = 0;
	int hold_done = 0;
	int hold_left = 0;
	int err_count = 0;
	int n_ticks = 0, n_reads = 0, n_results = 0, n_short = 0, n_long = 0, n_writes = 0;
	int n_queued = 0;
	int quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic model_reset();
		cfg_interval  = RST_SAMPLE_INTERVAL;
		cfg_long_lim  = RST_LONG_HOLD_LIMIT;
		cfg_short_min = RST_SHORT_MIN_COUNT;
		cfg_short_max = RST_SHORT_MAX_COUNT;
		for (int k = 0; k < KEY_REGS; k++) key_reg[k] = CODE_W'(k + 1);
		tick_cnt = '0;
		for (int b = 0; b < NB; b++) begin
			btn_down[b] = 1'b0;
			hold_cnt[b] = '0;
			btn_mode[b] = MODE_NONE;
		end
	endtask

	function automatic logic [EVENT_W-1:0] classify_beat(logic req, logic [CODE_W-1:0] code);
		logic now;
		logic [EVENT_W-1:0] ev;
		ev = '0;
		if (req == REQ_TICK) begin
			if (tick_cnt != CNT_MAX) tick_cnt++;
			if (tick_cnt > cfg_interval) begin
				for (int b = 0; b < NB; b++) begin
					now = (b < KEY_REGS) && (code == key_reg[b]);
					if (!btn_down[b]) begin
						hold_cnt[b] = '0;
						if (now) btn_down[b] = 1'b1;
						else btn_mode[b] = MODE_NONE;
					end else if (now) begin
						if (hold_cnt[b] != CNT_MAX) hold_cnt[b]++;
						if (hold_cnt[b] > cfg_long_lim) begin
							hold_cnt[b] = '0;
							btn_mode[b] = MODE_LONG;
						end
					end else begin
						btn_down[b] = 1'b0;
						if (btn_mode[b] != MODE_LONG && cfg_short_min <= hold_cnt[b]
								&& hold_cnt[b] < cfg_short_max)
							btn_mode[b] = MODE_SHORT;
					end
				end
				tick_cnt = '0;
			end
		end else begin
			for (int b = NB - 1; b >= 0; b--)
				if (btn_mode[b] == MODE_LONG) ev = EVENT_W'(NB + b + 1);
			for (int b = NB - 1; b >= 0; b--)
				if (btn_mode[b] == MODE_SHORT) ev = EVENT_W'(b + 1);
			if (ev > NB) btn_mode[ev - NB - 1] = MODE_NONE;
			else if (ev != 0) btn_mode[ev - 1] = MODE_NONE;
		end
		return ev;
	endfunction

	task automatic report_event_error(string what, logic [EVENT_W-1:0] got,
			logic [EVENT_W-1:0] want);
		if (err_count < 30)
			$display("%0t: %s key_event got %0d want %0d", $realtime, what, got, want);
		err_count++;
	endtask

	// driver: input beats change on the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!(in_valid && !in_taken)) begin
			if (req_beats.size() != 0 && !(req_beats[0].drain_first && events_due.size() != 0)
					&& $urandom_range(99) >= idle_pct) begin
				req_type   <= req_beats[0].req;
				touch_code <= req_beats[0].code;
				in_valid   <= 1'b1;
				void'(req_beats.pop_front());
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall, with long hold-offs on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (hold_done < hold_req) begin
			hold_done++;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < idle_pct);
		end
	end

	// monitor: both channels sampled on the rising edge
	always @(posedge clk) begin
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= in_valid && !in_stall;
			if (out_valid && !out_stall) begin
				n_results++;
				if (key_event inside {[1:NB]}) n_short++;
				if (key_event > NB) n_long++;
				if (events_due.size() == 0) begin
					report_event_error("unexpected beat", key_event, '0);
				end else begin
					want_event = events_due.pop_front();
					if (key_event !== want_event)
						report_event_error("mismatch", key_event, want_event);
				end
			end
			if (in_valid && !in_stall) begin
				if (req_type == REQ_TICK) n_ticks++;
				else n_reads++;
				events_due.push_back(classify_beat(req_type, touch_code));
			end
		end
	end

	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !arst_n)
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("watchdog: no beat for %0d cycles, %0d results pending",
			QUIET_LIMIT, events_due.size());
		$display("testbench NOT OK");
		$finish;
	end

	task automatic push_beat(logic req, logic [CODE_W-1:0] code, bit drain = 1'b0);
		req_beat_t bt;
		bt.req = req;
		bt.code = code;
		bt.drain_first = drain;
		req_beats.push_back(bt);
		n_queued++;
	endtask

	task automatic push_ticks(logic [CODE_W-1:0] code, int n);
		repeat (n) push_beat(REQ_TICK, code);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_SAMPLE_INTERVAL: cfg_interval  = val;
			REG_LONG_HOLD_LIMIT: cfg_long_lim  = val;
			REG_SHORT_MIN_COUNT: cfg_short_min = val;
			REG_SHORT_MAX_COUNT: cfg_short_max = val;
			default: key_reg[2'(idx - REG_KEY_CODE_FIRST)] = val[CODE_W-1:0];
		endcase
		n_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_thresholds(int intv, int lng, int smin, int smax);
		write_reg(REG_SAMPLE_INTERVAL, CNT_W'(intv));
		write_reg(REG_LONG_HOLD_LIMIT, CNT_W'(lng));
		write_reg(REG_SHORT_MIN_COUNT, CNT_W'(smin));
		write_reg(REG_SHORT_MAX_COUNT, CNT_W'(smax));
	endtask

	task automatic set_keys(int k0, int k1, int k2, int k3);
		// upper byte is don't-care for key registers
		write_reg(REG_KEY_CODE_FIRST,  {CODE_W'($urandom_range(255)), CODE_W'(k0)});
		write_reg(REG_KEY_CODE_SECOND, {CODE_W'($urandom_range(255)), CODE_W'(k1)});
		write_reg(REG_KEY_CODE_THIRD,  {CODE_W'($urandom_range(255)), CODE_W'(k2)});
		write_reg(REG_KEY_CODE_FOURTH, {CODE_W'($urandom_range(255)), CODE_W'(k3)});
	endtask

	task automatic wait_idle();
		while (req_beats.size() != 0 || in_valid || events_due.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// one press of a random button, a short release, then a few reads
	task automatic push_press_seq();
		int b, per, lim, n_s;
		logic [CODE_W-1:0] rel_code;
		b = $urandom_range(KEY_REGS - 1);
		per = int'(cfg_interval) + 1;
		lim = (cfg_long_lim > 36) ? 40 : int'(cfg_long_lim) + 4;
		n_s = $urandom_range(0, lim);
		push_ticks(key_reg[b], n_s * per + $urandom_range(1, per));
		rel_code = CODE_W'($urandom_range(255));
		if (rel_code == key_reg[b]) rel_code = ~rel_code;
		push_ticks(rel_code, $urandom_range(1, 2 * per));
		repeat ($urandom_range(0, 3)) push_beat(REQ_READ, '0);
	endtask

	task automatic run_random_phase(int n, bit hold_off);
		int start;
		bit drained;
		start = n_queued;
		drained = 1'b0;
		if (hold_off) hold_req++;
		while (n_queued - start < n) begin
			if ($urandom_range(99) < 80) begin
				push_press_seq();
			end else if ($urandom_range(1)) begin
				push_beat(REQ_READ, CODE_W'($urandom_range(255)));
			end else begin
				push_beat(REQ_TICK, ($urandom_range(1)) ? key_reg[$urandom_range(KEY_REGS - 1)]
					: CODE_W'($urandom_range(255)));
			end
			if (!drained && n_queued - start > n / 2) begin
				push_beat(REQ_READ, '0, 1'b1);
				drained = 1'b1;
			end
		end
		wait_idle();
	endtask

	initial begin
		model_reset();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: default registers, nothing sampled yet
		push_beat(REQ_READ, 8'hff);
		push_beat(REQ_TICK, 8'h00);
		push_beat(REQ_TICK, 8'hff);
		push_beat(REQ_TICK, 8'h01);
		wait_idle();

		// directed: sample every tick, long above 2, short window [1,3)
		set_thresholds(0, 2, 1, 3);
		push_ticks(8'h01, 2);
		push_ticks(8'h00, 1);
		push_ticks(8'h02, 4);
		push_ticks(8'h00, 1);
		repeat (3) push_beat(REQ_READ, '0);
		push_ticks(8'h04, 2);
		push_ticks(8'h03, 4);
		push_ticks(8'h00, 1);
		repeat (2) push_beat(REQ_READ, '0);
		// pending short cleared by a second released sample
		push_ticks(8'h01, 2);
		push_ticks(8'h00, 2);
		push_beat(REQ_READ, '0);
		wait_idle();

		set_thresholds(0, 5, 1, 4);
		set_keys(1, 2, 3, 4);
		run_random_phase(200, 1'b1);
		set_thresholds(2, 8, 0, 9);
		set_keys(0, 255, 8'h5a, 8'ha5);
		run_random_phase(200, 1'b0);
		set_thresholds(1, 0, 3, 3);
		set_keys(255, 0, 17, 200);
		run_random_phase(200, 1'b1);
		set_thresholds(3, 12, 5, 2);
		set_keys(7, 7, 9, 200);
		run_random_phase(200, 1'b0);
		set_thresholds(0, 4, 0, 65535);
		set_keys(1, 2, 3, 4);
		run_random_phase(200, 1'b0);
		set_thresholds(0, 6, 65535, 0);
		set_keys($urandom_range(255), $urandom_range(255), $urandom_range(255),
			$urandom_range(255));
		run_random_phase(100, 1'b1);

		// back to back run with no idling at all
		idle_pct = 0;
		set_thresholds(0, 4, 1, 4);
		set_keys(1, 2, 3, 4);
		run_random_phase(100, 1'b0);
		idle_pct = 18;

		set_thresholds($urandom_range(0, 3), $urandom_range(0, 15), $urandom_range(0, 6),
			$urandom_range(0, 16));
		run_random_phase(100, 1'b1);

		wait_idle();
		repeat (10) @(posedge clk);
		$display("covered %0d ticks, %0d reads, %0d config writes", n_ticks, n_reads, n_writes);
		$display("checked %0d results: %0d short, %0d long, %0d errors",
			n_results, n_short, n_long, err_count);
		if (err_count == 0 && events_due.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

// ===== button_press_classifier_core.f =====
src/bpc_pkg.sv
src/bpc_button.sv
src/button_press_classifier_core.sv
tb/sv/testbench.sv
